[sv/tfpe_pkg.sv]
// Shared types, constants and a helper function for the tagged frame payload extractor.
`default_nettype none

package tfpe_pkg;

  // Request payloads
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       buffer_end;
  } tfpe_in_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_last;
  } tfpe_out_t;

  // Decoded hex digit
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } tfpe_hex_t;

  // Tag layout: seven history bytes (newest at index 0), then the closing ':'
  localparam int unsigned TAG_CELLS = 7;
  localparam logic [7:0] TAG_CHARS [TAG_CELLS] = '{
    8'h53,  // 'S'
    8'h43,  // 'C'
    8'h4E,  // 'N'
    8'h41,  // 'A'
    8'h2B,  // '+'
    8'h4B,  // 'K'
    8'h4F   // 'O'
  };
  localparam logic [7:0] TAG_END_CHAR = 8'h3A;  // ':'

  localparam logic [7:0] HDR_SKIP_RST = 8'd8;

  // Offset counter: reaches frame length + 1, so one bit above a byte
  localparam int unsigned SINCE_W = 9;
  localparam logic [SINCE_W-1:0] SINCE_IDLE   = 9'd0;
  localparam logic [SINCE_W-1:0] SINCE_DIGIT1 = 9'd1;
  localparam logic [SINCE_W-1:0] SINCE_DIGIT2 = 9'd2;
  localparam logic [SINCE_W-1:0] SINCE_BODY   = 9'd3;

  // First length digit is held as 16 + digit so a zero value means "not hex"
  localparam logic [3:0] LEN_FIRST_MARK = 4'h1;

  function automatic tfpe_hex_t hex_decode(input logic [7:0] c);
    tfpe_hex_t h;
    h.ok  = 1'b0;
    h.val = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h61 + 8'd10);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

[sv/tagged_frame_payload_extractor.sv]
// Top level of the tagged frame payload extractor: history cell chain, frame tracker, output skid.
//
// Usage
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one stream byte per request,
//   with buffer_end set on the last byte of a reply buffer. Output channel
//   (out_valid_o / out_ready_i / out_data_o) carries extracted payload bytes, frame_last
//   set on the final byte of a frame's window.
//   A row of seven history cells shifts the stream along and compares each byte with its
//   tag character; the tracker sees the tag when the closing ':' arrives.
//   Throughput: one input byte per cycle while the skid is empty. Each byte is handled in the
//   cycle it is accepted; its payload byte is registered in the output register or the skid.
//   Buffer end clears the history and frame state after that byte; the header skip
//   register keeps its value.
//   first_header_skip is written through cfg_we_i / cfg_wdata_i; write it
//   only while no byte is in flight. Reset value 8.
//   Receiver stall: results sit in an output register backed by a one-entry skid, so a
//   request is still taken in the cycle the output stalls; in_ready_o drops only once
//   the skid holds a result, and rises again as soon as the receiver takes one.
//   Reset (rst_ni, asynchronous, active low) empties the output and restores all state.
`default_nettype none

module tagged_frame_payload_extractor (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  tfpe_pkg::tfpe_in_t      in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output tfpe_pkg::tfpe_out_t     out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i
);

  import tfpe_pkg::*;

  logic       fire;
  logic [7:0] skip_q;
  logic [7:0] chain   [TAG_CELLS+1];
  logic [TAG_CELLS-1:0] match;
  logic       prefix_hit;
  logic       res_valid;
  tfpe_out_t  res;

  logic       main_vld_q, main_vld_d;
  logic       skid_vld_q, skid_vld_d;
  tfpe_out_t  main_q, main_d;
  tfpe_out_t  skid_q, skid_d;
  logic       push;
  logic       pop;

  assign in_ready_o = ~skid_vld_q;
  assign fire       = in_valid_i & in_ready_o;

  // Header skip register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= HDR_SKIP_RST;
    end else if (cfg_we_i) begin
      skip_q <= cfg_wdata_i;
    end
  end

  // History cell chain, newest byte enters cell 0
  assign chain[0] = in_data_i.stream_byte;

  for (genvar g = 0; g < TAG_CELLS; g++) begin : g_cell
    tfpe_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (fire),
      .clr_i      (in_data_i.buffer_end),
      .byte_i     (chain[g]),
      .tag_char_i (TAG_CHARS[g]),
      .byte_o     (chain[g+1]),
      .match_o    (match[g])
    );
  end

  assign prefix_hit = &match;

  tfpe_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .in_i         (in_data_i),
    .prefix_hit_i (prefix_hit),
    .skip_i       (skip_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Output register with skid entry
  assign push = fire & res_valid;
  assign pop  = main_vld_q & out_ready_i;

  always_comb begin
    main_vld_d = main_vld_q;
    main_d     = main_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (!main_vld_q || pop) begin
      if (skid_vld_q) begin
        main_vld_d = 1'b1;
        main_d     = skid_q;
        skid_vld_d = push;
        skid_d     = res;
      end else begin
        main_vld_d = push;
        main_d     = res;
      end
    end else if (push) begin
      skid_vld_d = 1'b1;
      skid_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;

endmodule

`default_nettype wire

[sv/tfpe_cell.sv]
// One history cell: holds a byte of the recent stream and compares it with its tag character.
`default_nettype none

module tfpe_cell (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       clr_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [7:0] tag_char_i,
  output logic      [7:0] byte_o,
  output logic            match_o
);

  logic [7:0] byte_q;

  // Shift in the neighbour's byte on each request; buffer end empties the cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (en_i) begin
      byte_q <= clr_i ? 8'h00 : byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign match_o = (byte_q == tag_char_i);

endmodule

`default_nettype wire

[sv/tfpe_frame.sv]
// Frame tracker: length digits, window counters, header skip and result generation.
`default_nettype none

module tfpe_frame (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fire_i,
  input  tfpe_pkg::tfpe_in_t      in_i,
  input  wire logic               prefix_hit_i,
  input  wire logic [7:0]         skip_i,
  output logic                    res_valid_o,
  output tfpe_pkg::tfpe_out_t     res_o
);

  import tfpe_pkg::*;

  logic [SINCE_W-1:0] since_q, since_d;
  logic [7:0]         len_q, len_d;
  logic               first_q, first_d;
  logic [7:0]         rem_q, rem_d;

  logic [8:0]  idx;
  logic [7:0]  skip_eff;
  logic        emit_ok;
  logic        check;
  logic [7:0]  len_new;
  tfpe_hex_t   hex;

  // Window position of the current byte; a borrow counts as past any skip
  assign idx      = {1'b0, len_q} - {1'b0, rem_q};
  assign skip_eff = first_q ? skip_i : 8'h00;
  assign emit_ok  = idx[8] | (idx[7:0] >= skip_eff);
  assign hex      = hex_decode(in_i.stream_byte);

  always_comb begin
    since_d     = since_q;
    len_d       = len_q;
    first_d     = first_q;
    rem_d       = rem_q;
    check       = 1'b1;
    len_new     = 8'h00;
    res_valid_o = 1'b0;
    res_o.payload_byte = in_i.stream_byte;
    res_o.frame_last   = (rem_q == 8'd1);

    if (fire_i) begin
      // emit from the open window
      if (rem_q != 8'd0) begin
        res_valid_o = emit_ok;
        rem_d       = rem_q - 8'd1;
        if (rem_q == 8'd1) begin
          first_d = 1'b0;
        end
      end

      // length digits, then pause while the offset counter is within the frame length
      if (since_q != SINCE_IDLE) begin
        check = 1'b0;
        if (since_q == SINCE_DIGIT1) begin
          len_d   = hex.ok ? {LEN_FIRST_MARK, hex.val} : 8'h00;
          since_d = SINCE_DIGIT2;
        end else if (since_q == SINCE_DIGIT2) begin
          if (len_q == 8'h00) begin
            len_new = 8'h00;
          end else if (!hex.ok) begin
            len_new = {4'h0, len_q[3:0]};
          end else begin
            len_new = {len_q[3:0], hex.val};
          end
          len_d = len_new;
          rem_d = len_new;
          if (len_new == 8'h00) begin
            first_d = 1'b0;
          end
          since_d = SINCE_BODY;
        end else if (since_q > {1'b0, len_q}) begin
          check   = 1'b1;
          since_d = SINCE_IDLE;
        end else begin
          since_d = since_q + SINCE_W'(1);
        end
      end

      // tag closes on this byte
      if (check && prefix_hit_i && (in_i.stream_byte == TAG_END_CHAR)) begin
        since_d = SINCE_DIGIT1;
        len_d   = 8'h00;
      end

      // buffer end drops everything after the byte is handled
      if (in_i.buffer_end) begin
        since_d = SINCE_IDLE;
        len_d   = 8'h00;
        first_d = 1'b1;
        rem_d   = 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_q <= SINCE_IDLE;
      len_q   <= 8'h00;
      first_q <= 1'b1;
      rem_q   <= 8'h00;
    end else begin
      since_q <= since_d;
      len_q   <= len_d;
      first_q <= first_d;
      rem_q   <= rem_d;
    end
  end

endmodule

`default_nettype wire

[sv/tfpe_checker.sv]
// Port-level checks for the tagged frame payload extractor, bound to the top level.
`default_nettype none

module tfpe_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_o,
  input  tfpe_pkg::tfpe_in_t      in_data_i,
  input  wire logic               out_valid_o,
  input  wire logic               out_ready_i,
  input  tfpe_pkg::tfpe_out_t     out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // a result only appears after an input request
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result appeared without an input request");

  // back-pressure only while a result is already waiting
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // ready drops only when a stalled output met a new request
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i && in_valid_i))
    else $error("input ready fell without a stalled output");

endmodule

bind tagged_frame_payload_extractor tfpe_checker u_tfpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
